>>> hw/rtl/bsfa_pkg.sv
// ----------------------------------------------------------------------------
// bsfa_pkg
// Shared types and constants of the Biot-Savart field accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfa_pkg;

	// Largest magnitude of one separation component (raw Q16.16)
	localparam logic signed [32:0] R_LIM     = 33'sd2147483647;
	// Accumulator clamp ahead of output scaling
	localparam logic signed [63:0] SUM_CLAMP = 64'sd140737488355328;
	// mu0/4pi as 1e-7 * 2^39, rounded
	localparam logic signed [16:0] OUT_K     = 17'sd54976;
	// Saturated quotient
	localparam logic [62:0]        Q_MAX     = {63{1'b1}};

	// One classified sample, handed from the front to the back
	typedef struct packed {
		logic signed [63:0] p_x;
		logic signed [63:0] p_y;
		logic signed [63:0] p_z;
		logic [63:0]        d2;
		logic [31:0]        r;
		logic [30:0]        w;
		logic               last;
		logic               three;
		logic               singular;
	} bsfa_work_t;

	typedef struct packed {
		logic        start;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] divisor;
	} bsfa_div_req_t;

	typedef struct packed {
		logic        done;
		logic [62:0] quot;
	} bsfa_div_resp_t;

endpackage

`default_nettype wire

>>> hw/rtl/bsfa_sample_if.sv
// ----------------------------------------------------------------------------
// bsfa_sample_if
// Valid/ready channel carrying one source quadrature sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfa_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] obs_x;
	logic signed [31:0] obs_y;
	logic signed [31:0] obs_z;
	logic signed [31:0] src_x;
	logic signed [31:0] src_y;
	logic signed [31:0] src_z;
	logic signed [31:0] cur_x;
	logic signed [31:0] cur_y;
	logic signed [31:0] cur_z;
	logic [30:0]        weight;
	logic               last_sample;

	modport source (output valid, obs_x, obs_y, obs_z, src_x, src_y, src_z,
		cur_x, cur_y, cur_z, weight, last_sample, input ready);
	modport sink (input valid, obs_x, obs_y, obs_z, src_x, src_y, src_z,
		cur_x, cur_y, cur_z, weight, last_sample, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bsfa_field_if.sv
// ----------------------------------------------------------------------------
// bsfa_field_if
// Valid/ready channel carrying one accumulated field result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfa_field_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] field_x;
	logic signed [31:0] field_y;
	logic signed [31:0] field_z;
	logic               singular_seen;

	modport source (output valid, field_x, field_y, field_z, singular_seen, input ready);
	modport sink (input valid, field_x, field_y, field_z, singular_seen, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bsfa_front.sv
// ----------------------------------------------------------------------------
// bsfa_front
// Accepts a sample, forms R, cross products, |R|^2 and |R|, classifies it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfa_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           three_dim_mode,
	bsfa_sample_if.sink         in_ch,
	output bsfa_pkg::bsfa_work_t work,
	output logic                push,
	input  wire logic           full
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_SQRT = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	localparam logic [3:0] LAST_PROD = 4'd8;
	localparam logic [3:0] SQRT_LOAD = 4'd10;

	function automatic logic signed [31:0] clamp_r(input logic signed [32:0] d);
		logic signed [31:0] v;
		if (d > bsfa_pkg::R_LIM) v = 32'sh7FFF_FFFF;
		else if (d < -bsfa_pkg::R_LIM) v = 32'sh8000_0001;
		else v = d[31:0];
		return v;
	endfunction

	fstate_t            state_q;
	logic signed [31:0] rx_q, ry_q, rz_q, jx_q, jy_q, jz_q;
	logic [30:0]        w_q;
	logic               last_q, three_q;
	logic signed [63:0] px_q, py_q, pz_q;
	logic [63:0]        d2_q;
	logic [3:0]         cnt_q;
	logic signed [63:0] prod_s1;
	logic               pvld_s1;
	logic [3:0]         psel_s1;
	logic [63:0]        n_q, res_q, bit_q;
	logic signed [31:0] op_a, op_b;
	logic [63:0]        try_sum;

	assign in_ch.ready = (state_q == F_IDLE);
	assign push        = (state_q == F_PUSH) && !full;

	// operand select for the shared multiplier
	always_comb begin
		case (cnt_q)
			4'd0: begin op_a = rx_q; op_b = rx_q; end
			4'd1: begin op_a = ry_q; op_b = ry_q; end
			4'd2: begin op_a = rz_q; op_b = rz_q; end
			4'd3: begin op_a = jy_q; op_b = rz_q; end
			4'd4: begin op_a = jz_q; op_b = ry_q; end
			4'd5: begin op_a = jz_q; op_b = rx_q; end
			4'd6: begin op_a = jx_q; op_b = rz_q; end
			4'd7: begin op_a = jx_q; op_b = ry_q; end
			4'd8: begin op_a = jy_q; op_b = rx_q; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign try_sum = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			pvld_s1 <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						state_q <= F_MUL;
						cnt_q   <= '0;
						pvld_s1 <= 1'b0;
					end
				end
				F_MUL: begin
					pvld_s1 <= (cnt_q <= LAST_PROD);
					if (cnt_q == SQRT_LOAD) begin
						state_q <= (three_q && d2_q != '0) ? F_SQRT : F_PUSH;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				F_SQRT: begin
					if (bit_q == '0) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_ch.valid) begin
			rx_q    <= clamp_r({in_ch.obs_x[31], in_ch.obs_x} - {in_ch.src_x[31], in_ch.src_x});
			ry_q    <= clamp_r({in_ch.obs_y[31], in_ch.obs_y} - {in_ch.src_y[31], in_ch.src_y});
			// 2D: drop the z separation and the in-plane current
			rz_q    <= three_dim_mode ?
				clamp_r({in_ch.obs_z[31], in_ch.obs_z} - {in_ch.src_z[31], in_ch.src_z}) : '0;
			jx_q    <= three_dim_mode ? in_ch.cur_x : '0;
			jy_q    <= three_dim_mode ? in_ch.cur_y : '0;
			jz_q    <= in_ch.cur_z;
			w_q     <= in_ch.weight;
			last_q  <= in_ch.last_sample;
			three_q <= three_dim_mode;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			d2_q    <= '0;
		end
		if (state_q == F_MUL) begin
			prod_s1 <= 64'(op_a) * 64'(op_b);
			psel_s1 <= cnt_q;
			if (pvld_s1) begin
				case (psel_s1)
					4'd0, 4'd1, 4'd2: d2_q <= d2_q + prod_s1;
					4'd3: px_q <= px_q + prod_s1;
					4'd4: px_q <= px_q - prod_s1;
					4'd5: py_q <= py_q + prod_s1;
					4'd6: py_q <= py_q - prod_s1;
					4'd7: pz_q <= pz_q + prod_s1;
					4'd8: pz_q <= pz_q - prod_s1;
					default: ;
				endcase
			end
			if (cnt_q == SQRT_LOAD) begin
				n_q   <= d2_q;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
		end
		// one result bit per cycle, two radicand bits consumed
		if (state_q == F_SQRT && bit_q != '0) begin
			if (n_q >= try_sum) begin
				n_q   <= n_q - try_sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign work.p_x      = px_q;
	assign work.p_y      = py_q;
	assign work.p_z      = pz_q;
	assign work.d2       = d2_q;
	assign work.r        = res_q[31:0];
	assign work.w        = w_q;
	assign work.last     = last_q;
	assign work.three    = three_q;
	assign work.singular = (d2_q == '0);

endmodule

`default_nettype wire

>>> hw/rtl/bsfa_queue.sv
// ----------------------------------------------------------------------------
// bsfa_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfa_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bsfa_pkg::bsfa_work_t din,
	input  wire logic                 push,
	output logic                      full,
	output bsfa_pkg::bsfa_work_t      dout,
	output logic                      not_empty,
	input  wire logic                 pop
);

	bsfa_pkg::bsfa_work_t mem_q [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

endmodule

`default_nettype wire

>>> hw/rtl/bsfa_divider.sv
// ----------------------------------------------------------------------------
// bsfa_divider
// Restoring divider, 128/64 bits, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfa_divider (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bsfa_pkg::bsfa_div_req_t req,
	output bsfa_pkg::bsfa_div_resp_t     resp
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, lo_q, div_q, q_q;
	logic [62:0] quot_q;
	logic [64:0] rem_sh;
	logic        ge;
	logic [63:0] rem_next, q_next;

	always_comb begin
		rem_sh   = {rem_q, lo_q[63]};
		ge       = rem_sh >= {1'b0, div_q};
		rem_next = ge ? 64'(rem_sh - {1'b0, div_q}) : rem_sh[63:0];
		q_next   = {q_q[62:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// quotient would not fit: saturate at once
				if (req.hi >= req.divisor) done_q <= 1'b1;
				else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.hi;
			lo_q   <= req.lo;
			div_q  <= req.divisor;
			q_q    <= '0;
			quot_q <= bsfa_pkg::Q_MAX;
		end else if (busy_q) begin
			rem_q <= rem_next;
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= q_next;
			if (cnt_q == 6'd63) quot_q <= q_next[63] ? bsfa_pkg::Q_MAX : q_next[62:0];
		end
	end

	assign resp.done = done_q;
	assign resp.quot = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/bsfa_back.sv
// ----------------------------------------------------------------------------
// bsfa_back
// Evaluates the field terms, keeps the saturating sums, scales the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfa_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bsfa_pkg::bsfa_work_t head,
	input  wire logic                 head_vld,
	output logic                      pop,
	bsfa_field_if.source              out_ch
);

	typedef enum logic [10:0] {
		B_IDLE      = 11'b000_0000_0001,
		B_MAG       = 11'b000_0000_0010,
		B_MUL       = 11'b000_0000_0100,
		B_DIV1_GO   = 11'b000_0000_1000,
		B_DIV1_WAIT = 11'b000_0001_0000,
		B_DIV2_GO   = 11'b000_0010_0000,
		B_DIV2_WAIT = 11'b000_0100_0000,
		B_ACC       = 11'b000_1000_0000,
		B_LAST_CHK  = 11'b001_0000_0000,
		B_OUT_MUL   = 11'b010_0000_0000,
		B_OUT_RND   = 11'b100_0000_0000
	} bstate_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] s;
		if (v > 64'sd2147483647) s = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) s = 32'sh8000_0000;
		else s = v[31:0];
		return s;
	endfunction

	function automatic logic signed [48:0] clamp_sum(input logic signed [63:0] s);
		logic signed [63:0] c;
		if (s > bsfa_pkg::SUM_CLAMP) c = bsfa_pkg::SUM_CLAMP;
		else if (s < -bsfa_pkg::SUM_CLAMP) c = -bsfa_pkg::SUM_CLAMP;
		else c = s;
		return c[48:0];
	endfunction

	bstate_t                  state_q;
	bsfa_pkg::bsfa_work_t     wk_q;
	logic [1:0]               comp_q;
	logic [63:0]              mag_q;
	logic                     neg_q;
	logic [62:0]              prod_lo_s1, prod_hi_s1;
	logic [62:0]              t_q;
	logic signed [63:0]       sum_q [3];
	logic                     flag_q;
	logic signed [63:0]       outp_q [3];
	logic                     out_valid_q;
	logic signed [31:0]       fx_q, fy_q, fz_q;
	logic                     sing_q;
	logic signed [63:0]       p_sel;
	logic [127:0]             num;
	logic signed [63:0]       term;
	logic signed [64:0]       acc;
	logic signed [63:0]       acc_sat;
	logic [1:0]               last_comp;
	logic                     out_free;
	logic signed [63:0]       rnd [3];
	bsfa_pkg::bsfa_div_req_t  dreq;
	bsfa_pkg::bsfa_div_resp_t dresp;

	bsfa_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.resp   (dresp)
	);

	always_comb begin
		case (comp_q)
			2'd0:    p_sel = wk_q.p_x;
			2'd1:    p_sel = wk_q.p_y;
			default: p_sel = wk_q.p_z;
		endcase
		num       = {65'd0, prod_lo_s1} + {33'd0, prod_hi_s1, 32'd0};
		term      = neg_q ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});
		acc       = {sum_q[comp_q][63], sum_q[comp_q]} + {term[63], term};
		if (acc[64] != acc[63]) acc_sat = acc[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else acc_sat = acc[63:0];
		last_comp = wk_q.three ? 2'd2 : 2'd1;
		out_free  = !out_valid_q || out_ch.ready;
		for (int i = 0; i < 3; i++) begin
			rnd[i] = wk_q.three ? ((outp_q[i] + 64'sd1073741824) >>> 31)
				: ((outp_q[i] + 64'sd536870912) >>> 30);
		end
		dreq.start   = (state_q == B_DIV1_GO) || (state_q == B_DIV2_GO);
		if (state_q == B_DIV2_GO) begin
			dreq.hi      = {49'd0, t_q[62:48]};
			dreq.lo      = {t_q[47:0], 16'd0};
			dreq.divisor = {32'd0, wk_q.r};
		end else begin
			dreq.hi      = num[127:64];
			dreq.lo      = num[63:0];
			dreq.divisor = wk_q.d2;
		end
	end

	assign pop = (state_q == B_IDLE) && head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			flag_q      <= 1'b0;
			comp_q      <= '0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (head_vld) begin
						comp_q <= '0;
						if (head.singular) begin
							flag_q  <= 1'b1;
							state_q <= B_LAST_CHK;
						end else begin
							state_q <= B_MAG;
						end
					end
				end
				B_MAG:       state_q <= B_MUL;
				B_MUL:       state_q <= B_DIV1_GO;
				B_DIV1_GO:   state_q <= B_DIV1_WAIT;
				B_DIV1_WAIT: begin
					if (dresp.done) state_q <= wk_q.three ? B_DIV2_GO : B_ACC;
				end
				B_DIV2_GO:   state_q <= B_DIV2_WAIT;
				B_DIV2_WAIT: begin
					if (dresp.done) state_q <= B_ACC;
				end
				B_ACC: begin
					sum_q[comp_q] <= acc_sat;
					if (comp_q == last_comp) state_q <= B_LAST_CHK;
					else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= B_MAG;
					end
				end
				B_LAST_CHK:  state_q <= wk_q.last ? B_OUT_MUL : B_IDLE;
				B_OUT_MUL:   state_q <= B_OUT_RND;
				B_OUT_RND: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						flag_q      <= 1'b0;
						for (int i = 0; i < 3; i++) sum_q[i] <= '0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) wk_q <= head;
		if (state_q == B_MAG) begin
			neg_q <= p_sel[63];
			mag_q <= p_sel[63] ? 64'(-p_sel) : p_sel;
		end
		if (state_q == B_MUL) begin
			prod_lo_s1 <= 63'(mag_q[31:0]) * 63'(wk_q.w);
			prod_hi_s1 <= 63'(mag_q[63:32]) * 63'(wk_q.w);
		end
		if ((state_q == B_DIV1_WAIT || state_q == B_DIV2_WAIT) && dresp.done) t_q <= dresp.quot;
		if (state_q == B_OUT_MUL) begin
			for (int i = 0; i < 3; i++) begin
				outp_q[i] <= 64'(clamp_sum(sum_q[i])) * 64'(bsfa_pkg::OUT_K);
			end
		end
		if (state_q == B_OUT_RND && out_free) begin
			fx_q   <= sat32(rnd[0]);
			fy_q   <= sat32(rnd[1]);
			fz_q   <= wk_q.three ? sat32(rnd[2]) : '0;
			sing_q <= flag_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.field_x       = fx_q;
	assign out_ch.field_y       = fy_q;
	assign out_ch.field_z       = fz_q;
	assign out_ch.singular_seen = sing_q;

endmodule

`default_nettype wire

>>> hw/rtl/biot_savart_field_accumulator.sv
// ----------------------------------------------------------------------------
// biot_savart_field_accumulator
// Sums Biot-Savart quadrature terms per observation point, emits Q8.24 tesla.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one source sample per transfer (observation point, source point,
//            current density, weight, last_sample), valid/ready.
//   out_ch : one field result per sample marked last_sample, valid/ready.
//   cfg_we / cfg_wdata : write three_dim_mode (1 = 3D law, 0 = 2D law);
//            write only while the block is idle.
// Throughput: the back end sets the rate. Each term component runs through a
//   one-bit-per-cycle 128/64 divider, twice in 3D. A sample has three
//   components in 3D and two in 2D; a sample at zero distance skips the
//   divider. The front end (one shared 32x32 multiplier over nine products,
//   then a bit-serial square root) runs ahead through a two-entry queue.
// Output: after the last sample's terms are summed, the sums pass B_LAST_CHK,
//   are scaled in B_OUT_MUL and rounded in B_OUT_RND into the output register.
// Reset: sums and singular flag clear, mode returns to 3D, channels go idle.
// Stall: a result waits in the output register; the back end holds in its
//   rounding step only when a second result is ready before the first left.
// ----------------------------------------------------------------------------
`default_nettype none

module biot_savart_field_accumulator (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata,
	bsfa_sample_if.sink  in_ch,
	bsfa_field_if.source out_ch
);

	logic                 mode_q;
	bsfa_pkg::bsfa_work_t front_work, queue_head;
	logic                 push, full, head_vld, pop;

	// mode register, 3D after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b1;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	// front: accept, form R, products, distance
	bsfa_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.three_dim_mode (mode_q),
		.in_ch          (in_ch),
		.work           (front_work),
		.push           (push),
		.full           (full)
	);

	// decouple front and back
	bsfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (front_work),
		.push      (push),
		.full      (full),
		.dout      (queue_head),
		.not_empty (head_vld),
		.pop       (pop)
	);

	// back: divide, accumulate, scale
	bsfa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (queue_head),
		.head_vld (head_vld),
		.pop      (pop),
		.out_ch   (out_ch)
	);

	// never write into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");

	// never take from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_vld)) else $error("pop from empty queue");

	// no queue write right after a transfer into the front
	a_push_not_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !push) else $error("push right after accept");

endmodule

`default_nettype wire

>>> test/bsfa_field_checker.sv
// ----------------------------------------------------------------------------
// bsfa_field_checker
// Watches the sample and field channels of the Biot-Savart accumulator,
// predicts every field result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfa_field_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	bsfa_sample_if    in_mon,
	bsfa_field_if     out_mon,
	output int        fails,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic               sing;
	} field_t;

	field_t             field_q[$];
	logic               mode_3d;
	logic signed [63:0] acc_x, acc_y, acc_z;
	logic               sing_flag;
	int                 fail_cnt = 0;

	function automatic logic [63:0] quot_sat(input logic [63:0] a, b, z);
		logic [127:0] prod, q;
		prod = {64'd0, a} * {64'd0, b};
		q = prod / {64'd0, z};
		if (q > {65'd0, bsfa_pkg::Q_MAX}) return {1'b0, bsfa_pkg::Q_MAX};
		return q[63:0];
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] field_term(input logic signed [63:0] p,
			input logic [63:0] w, d2, r, input bit cube);
		logic [63:0] mag, t;
		mag = (p < 0) ? -p : p;
		t = quot_sat(mag, w, d2);
		if (cube) t = quot_sat(t, 64'd65536, r);
		return (p < 0) ? -$signed(t) : $signed(t);
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a, b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] to_tesla(input logic signed [63:0] s,
			input int sh);
		logic signed [63:0] v, k;
		k = bsfa_pkg::OUT_K;
		if (s > bsfa_pkg::SUM_CLAMP) s = bsfa_pkg::SUM_CLAMP;
		if (s < -bsfa_pkg::SUM_CLAMP) s = -bsfa_pkg::SUM_CLAMP;
		v = s * k + (64'sd1 <<< (sh - 1));
		v = v >>> sh;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] clamp_sep(input logic signed [63:0] d);
		logic signed [63:0] lim;
		lim = bsfa_pkg::R_LIM;
		if (d > lim) return lim;
		if (d < -lim) return -lim;
		return d;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		fail_cnt++;
	endtask

	assign fails = fail_cnt;

	always @(posedge clk or negedge arst_n) begin
		logic signed [63:0] ox, oy, oz, sx, sy, sz, rx, ry, rz, jx, jy, jz;
		logic [63:0]        d2, r, w;
		int                 sh;
		field_t             e;
		if (!arst_n) begin
			mode_3d   <= 1'b1;
			acc_x = 0; acc_y = 0; acc_z = 0;
			sing_flag = 0;
			field_q.delete();
		end else begin
			if (cfg_we) mode_3d <= cfg_wdata;
			// accept a sample: fold its term into the running sums
			if (in_mon.valid && in_mon.ready) begin
				ox = in_mon.obs_x; oy = in_mon.obs_y; oz = in_mon.obs_z;
				sx = in_mon.src_x; sy = in_mon.src_y; sz = in_mon.src_z;
				jx = in_mon.cur_x; jy = in_mon.cur_y; jz = in_mon.cur_z;
				w  = {33'd0, in_mon.weight};
				rx = clamp_sep(ox - sx);
				ry = clamp_sep(oy - sy);
				rz = clamp_sep(oz - sz);
				d2 = rx * rx + ry * ry;
				if (mode_3d) d2 = d2 + rz * rz;
				if (d2 == 0) begin
					sing_flag = 1'b1;
				end else if (mode_3d) begin
					r = root_floor(d2);
					acc_x = add_sat(acc_x, field_term(jy * rz - jz * ry, w, d2, r, 1));
					acc_y = add_sat(acc_y, field_term(jz * rx - jx * rz, w, d2, r, 1));
					acc_z = add_sat(acc_z, field_term(jx * ry - jy * rx, w, d2, r, 1));
				end else begin
					acc_x = add_sat(acc_x, field_term(-(jz * ry), w, d2, 1, 0));
					acc_y = add_sat(acc_y, field_term(jz * rx, w, d2, 1, 0));
				end
				if (in_mon.last_sample) begin
					sh = mode_3d ? 31 : 30;
					e.fx = to_tesla(acc_x, sh);
					e.fy = to_tesla(acc_y, sh);
					e.fz = mode_3d ? to_tesla(acc_z, 31) : 32'sd0;
					e.sing = sing_flag;
					field_q.push_back(e);
					acc_x = 0; acc_y = 0; acc_z = 0;
					sing_flag = 0;
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				if (field_q.size() == 0) begin
					report_mismatch("unexpected result", out_mon.field_x, 32'd0);
				end else begin
					e = field_q.pop_front();
					if (out_mon.field_x !== e.fx) report_mismatch("field_x", out_mon.field_x, e.fx);
					if (out_mon.field_y !== e.fy) report_mismatch("field_y", out_mon.field_y, e.fy);
					if (out_mon.field_z !== e.fz) report_mismatch("field_z", out_mon.field_z, e.fz);
					if (out_mon.singular_seen !== e.sing)
						report_mismatch("singular_seen", {31'd0, out_mon.singular_seen},
							{31'd0, e.sing});
				end
			end
		end
		pending = field_q.size();
	end

endmodule

`default_nettype wire

>>> test/biot_savart_field_accumulator_tb.sv
// ----------------------------------------------------------------------------
// biot_savart_field_accumulator_tb
// Drives source samples in groups per observation point through both field
// laws, with directed extremes and random groups under varied back-pressure;
// the checker predicts and compares every field result.
// ----------------------------------------------------------------------------
`default_nettype none

module biot_savart_field_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// drain wait, well past the time a 3D sample takes in the back end
	localparam int DRAIN_CYCLES = 700;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fails;
	int   pending;
	int   send_idle;   // percent of cycles the sender holds valid low
	int   recv_stall;  // percent of cycles the receiver holds ready low

	bsfa_sample_if smp_ch ();
	bsfa_field_if  fld_ch ();

	biot_savart_field_accumulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (smp_ch),
		.out_ch    (fld_ch)
	);

	bsfa_field_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_mon    (smp_ch),
		.out_mon   (fld_ch),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: drop ready at random according to the current phase
	always @(negedge clk) begin
		fld_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// present one sample and hold it until the transfer
	task automatic send_sample(input logic [31:0] ox, oy, oz, sx, sy, sz,
			jx, jy, jz, input logic [30:0] w, input logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			smp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		smp_ch.valid       <= 1'b1;
		smp_ch.obs_x       <= ox;
		smp_ch.obs_y       <= oy;
		smp_ch.obs_z       <= oz;
		smp_ch.src_x       <= sx;
		smp_ch.src_y       <= sy;
		smp_ch.src_z       <= sz;
		smp_ch.cur_x       <= jx;
		smp_ch.cur_y       <= jy;
		smp_ch.cur_z       <= jz;
		smp_ch.weight      <= w;
		smp_ch.last_sample <= last;
		do @(posedge clk); while (!smp_ch.ready);
		@(negedge clk);
	endtask

	// random coordinate: half the time a few metres, else any value or an extreme
	function automatic logic [31:0] rand_coord();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) return $urandom_range(0, 1 << 19) - (1 << 18);
		if (k < 8) return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [30:0] rand_weight();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) return 31'($urandom_range(0, 131072));
		if (k < 9) return 31'($urandom);
		return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
	endfunction

	// one observation point with a handful of sources, last one closes it
	task automatic send_group();
		logic [31:0] ox, oy, oz, sx, sy, sz;
		int          n;
		int          k;
		ox = rand_coord(); oy = rand_coord(); oz = rand_coord();
		n  = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
			k = $urandom_range(0, 19);
			// hit the zero-distance case now and then; in-plane only too
			if (k < 2) begin
				sx = ox; sy = oy; sz = oz;
			end else if (k == 2) begin
				sx = ox; sy = oy;
			end
			send_sample(ox, oy, oz, sx, sy, sz, rand_coord(), rand_coord(), rand_coord(),
				rand_weight(), i == n - 1);
		end
	endtask

	// settle the block, then write the mode while nothing is in flight
	task automatic set_mode(input logic m);
		smp_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input logic m, input int si, input int rs, input int groups);
		set_mode(m);
		send_idle  = si;
		recv_stall = rs;
		for (int g = 0; g < groups; g++) send_group();
	endtask

	// extremes of every field plus the named special cases, in one law
	task automatic directed_set();
		// far points: separation clamps, currents at both extremes
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
		send_sample(32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
		// unit distance, unit current, unit weight
		send_sample(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000, 1'b1);
		// zero distance only, then zero distance inside a group
		send_sample(32'h1234_5678, 32'h0, 32'hFFFF_0000, 32'h1234_5678, 32'h0, 32'hFFFF_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
		send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0001_0000, 32'h0, 32'h0, 31'h1, 1'b0);
		send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
			32'h0001_0000, 32'h0002_0000, 32'h0, 31'h1, 1'b1);
		// in-plane zero, out-of-plane offset: singular in 2D only
		send_sample(32'h0003_0000, 32'h0003_0000, 32'h0005_0000,
			32'h0003_0000, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000,
			31'h0001_0000, 1'b1);
		// weight zero
		send_sample(32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 1'b1);
		// tiny separation, huge weight: quotient and accumulator saturate
		for (int i = 0; i < 4; i++)
			send_sample(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, i == 3);
		send_sample(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.obs_x = '0; smp_ch.obs_y = '0; smp_ch.obs_z = '0;
		smp_ch.src_x = '0; smp_ch.src_y = '0; smp_ch.src_z = '0;
		smp_ch.cur_x = '0; smp_ch.cur_y = '0; smp_ch.cur_z = '0;
		smp_ch.weight = '0;
		smp_ch.last_sample = 1'b0;
		send_idle    = 0;
		recv_stall   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset mode (3D) first, then the 2D law
		directed_set();
		set_mode(1'b0);
		directed_set();

		run_phase(1'b1, 0, 0, 90);
		run_phase(1'b0, 88, 0, 90);
		run_phase(1'b1, 0, 88, 90);
		run_phase(1'b0, 35, 35, 90);
		run_phase(1'b1, 35, 35, 60);
		run_phase(1'b0, 0, 0, 40);

		// drain: release valid, wait for every result, then let the block settle
		smp_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hang guard, sized for 3D samples at full back-end cost with margin
	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
